// ----- design/field_map_bilinear_lookup_assert.svh -----
// Assertion macros used by the field map lookup checker.
`ifndef FIELD_MAP_BILINEAR_LOOKUP_ASSERT_SVH
`define FIELD_MAP_BILINEAR_LOOKUP_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define FMBL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define FMBL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/fmbl_pkg.sv -----
// Shared types and constants of the field map bilinear lookup.
package fmbl_pkg;

    localparam int GRID_X_DEF   = 32;
    localparam int GRID_Y_DEF   = 32;
    localparam int GRID_Z_DEF   = 64;
    localparam int PITCH_MM_DEF = 10;

    localparam int VAL_W       = 20;
    localparam int IDX_W       = 16;
    localparam int CRD_W       = 18;
    localparam int ENTRY_W     = 4 * VAL_W;
    localparam int TABLE_DEPTH = 65536;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    // Control bits that travel down the pipeline with each beat
    typedef struct packed
    {
        logic    valid;
        opcode_t op;
        logic    bad;
    } ctrl_t;

endpackage

// ----- design/fmbl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fmbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old word when the same address is written
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/fmbl_lane.sv -----
// One component lane: weighted corner sum and floor division by the squared pitch.
module fmbl_lane import fmbl_pkg::*; #(
    parameter int WW       = 16,
    parameter int PITCH_MM = PITCH_MM_DEF
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [3:0][VAL_W-1:0]       corner_val,
    input  logic [3:0][WW-1:0]          weight,
    output logic signed [VAL_W-1:0]     result
);

    localparam int PRW = VAL_W + WW + 1;
    localparam int SW  = PRW + 2;
    localparam int D   = PITCH_MM * PITCH_MM;
    localparam int UW  = VAL_W + $clog2(D) + 1;
    localparam int ULO = UW / 2;
    localparam int UHI = UW - ULO;
    localparam int MW  = UW + 1;
    localparam logic [MW-1:0]       RMUL = MW'((64'd1 << UW) / 64'(D));
    localparam logic signed [SW-9:0] UOFF = (SW-8)'(64'(D) << (VAL_W - 1));
    localparam logic [UW-1:0]       DV   = UW'(D);
    localparam logic [VAL_W-1:0]    SGN  = VAL_W'(1) << (VAL_W - 1);

    logic signed [PRW-1:0] prod_next [4];
    logic signed [PRW-1:0] prod_reg  [4];
    logic signed [SW-1:0]  sum;
    logic signed [SW-9:0]  sh;
    logic [UW-1:0]         u_next, u2_reg, u3_reg, u4_reg;
    logic [UHI+MW-1:0]     ph_reg;
    logic [ULO+MW-1:0]     pl_reg;
    logic [UW+MW-1:0]      full;
    logic [VAL_W-1:0]      qe_reg;
    logic [UW-1:0]         rem;
    logic [VAL_W-1:0]      q;
    logic [VAL_W-1:0]      result_reg;
    logic signed [VAL_W-1:0] cv [4];
    logic signed [WW:0]      ws [4];

    // Multiply each corner value by its weight
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            cv[k]        = corner_val[k];
            ws[k]        = {1'b0, weight[k]};
            prod_next[k] = cv[k] * ws[k];
        end
    end

    // Sum, drop the factor 256 by an arithmetic shift and offset to a non-negative dividend
    always_comb
    begin
        sum = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]) + SW'(prod_reg[3]);
        sh  = sum[SW-1:8];
        u_next = UW'(sh + UOFF);
    end

    // Reciprocal quotient estimate and one-step correction
    always_comb
    begin
        full = ((UW+MW)'(ph_reg) << ULO) + (UW+MW)'(pl_reg);
        rem  = u4_reg - UW'(qe_reg * DV);
        q    = (rem >= DV) ? qe_reg + VAL_W'(1) : qe_reg;
    end

    // Advance all lane stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            u2_reg     <= u_next;
            ph_reg     <= (UHI+MW)'(u2_reg[UW-1:ULO]) * (UHI+MW)'(RMUL);
            pl_reg     <= (ULO+MW)'(u2_reg[ULO-1:0]) * (ULO+MW)'(RMUL);
            u3_reg     <= u2_reg;
            qe_reg     <= full[UW+VAL_W-1:UW];
            u4_reg     <= u3_reg;
            result_reg <= q ^ SGN;
        end
    end

    assign result = result_reg;

endmodule

// ----- design/field_map_bilinear_lookup.sv -----
// Top level of the field map bilinear lookup pipeline.
//
//  channel  dir  tdata                                   tuser
//  s_*      in   entry_index,bx,by,bz,mag_in,px,py,pz    opcode
//  m_*      out  bx_out,by_out,bz_out,mag_out            out_of_range
//
//  One beat enters per cycle while the output does not stall; a query result leaves from the last stage register.
//  Writes and map reads both happen at stage 5 against four RAM copies,
//  one per cell corner, so all corners are read in one cycle.
//  Writes produce no output beat. The whole pipeline holds while an output
//  beat waits; reset clears the control bits only, map contents stay undefined.
module field_map_bilinear_lookup import fmbl_pkg::*; #(
    parameter int GRID_X   = GRID_X_DEF,
    parameter int GRID_Y   = GRID_Y_DEF,
    parameter int GRID_Z   = GRID_Z_DEF,
    parameter int PITCH_MM = PITCH_MM_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index[15:0] bx_in[35:16] by_in[55:36] bz_in[75:56] mag_in[95:76]
    // px[111:96] py[127:112] pz[145:128] zero[151:146]
    input  logic [151:0] s_tdata,
    // opcode[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // bx_out[19:0] by_out[39:20] bz_out[59:40] mag_out[79:60]
    output logic [79:0]  m_tdata,
    // out_of_range[0]
    output logic [0:0]   m_tuser
);

    localparam int P    = 16 * PITCH_MM;
    localparam int PW   = $clog2(P + 1);
    localparam int WW   = 2 * PW;
    localparam int XW   = CRD_W + 1;
    localparam int IW   = XW - 2;
    localparam int KOFF = (2 ** (CRD_W - 1) + P - 1) / P;
    localparam int GYZ  = GRID_Y * GRID_Z;
    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam logic [XW-1:0] XOFF = XW'(KOFF * P);
    localparam logic [XW-1:0] XMUL = XW'((2 ** XW) / P);
    localparam logic [XW-1:0] PV   = XW'(P);
    localparam int HALF [3] = '{GRID_X / 2, GRID_Y / 2, GRID_Z / 2};
    localparam int LIM  [3] = '{GRID_X - 1, GRID_Y - 1, GRID_Z};

    logic en;
    ctrl_t c_next, c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    ctrl_t c7_reg, c8_reg, c9_reg, c10_reg, c11_reg;

    logic [IDX_W-1:0]   idx1_reg, idx2_reg, idx3_reg, idx4_reg, idx5_reg;
    logic [ENTRY_W-1:0] data1_reg, data2_reg, data3_reg, data4_reg, data5_reg;
    logic signed [CRD_W-1:0] crd1_reg [3];
    logic [XW-1:0]      xo_next [3];
    logic [XW-1:0]      xo2_reg [3];
    logic [2*XW-1:0]    prod2_reg [3];
    logic [XW-1:0]      qe, rr, qc, fc;
    logic signed [IW-1:0] i_next [3];
    logic [PW-1:0]      f_next [2];
    logic signed [IW-1:0] i3_reg [3];
    logic [PW-1:0]      f3_reg [2];
    logic [PW-1:0]      f4_reg [2];
    logic               bad_idx;
    logic               bad4_reg;
    logic [31:0]        a0_next, a0_4_reg, a3;
    logic [AW-1:0]      addr5_reg [4];
    logic [PW-1:0]      gx, gy;
    logic [3:0][WW-1:0] w_next, w5_reg, w6_reg;
    logic               bad_next5;
    logic [ENTRY_W-1:0] rdata [4];
    logic               ram_we;
    logic [3:0][VAL_W-1:0] cv [4];
    logic signed [VAL_W-1:0] res [4];

    // Stall every stage while an output beat waits
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign c_next.valid = s_tvalid;
    assign c_next.op    = opcode_t'(s_tuser[0]);
    assign c_next.bad   = 1'b0;

    // Advance control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg  <= '0;
            c2_reg  <= '0;
            c3_reg  <= '0;
            c4_reg  <= '0;
            c5_reg  <= '0;
            c6_reg  <= '0;
            c7_reg  <= '0;
            c8_reg  <= '0;
            c9_reg  <= '0;
            c10_reg <= '0;
            c11_reg <= '0;
        end
        else if (en)
        begin
            c1_reg  <= c_next;
            c2_reg  <= c1_reg;
            c3_reg  <= c2_reg;
            c4_reg  <= '{valid: c3_reg.valid, op: c3_reg.op, bad: 1'b0};
            c5_reg  <= '{valid: c4_reg.valid, op: c4_reg.op, bad: bad_next5};
            c6_reg  <= c5_reg;
            c7_reg  <= c6_reg;
            c8_reg  <= c7_reg;
            c9_reg  <= c8_reg;
            c10_reg <= c9_reg;
            c11_reg <= c10_reg;
        end
    end

    // Offset coordinates to non-negative values for the pitch division
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            xo_next[a] = {crd1_reg[a][CRD_W-1], crd1_reg[a]} + XOFF;
        end
    end

    // Correct the reciprocal quotient and form grid index and fraction
    always_comb
    begin
        qe = '0;
        rr = '0;
        qc = '0;
        fc = '0;
        for (int a = 0; a < 3; a++)
        begin
            qe = prod2_reg[a][2*XW-1:XW];
            rr = xo2_reg[a] - XW'(qe * PV);
            if (rr >= PV)
            begin
                qc = qe + XW'(1);
                fc = rr - PV;
            end
            else
            begin
                qc = qe;
                fc = rr;
            end
            i_next[a] = IW'(int'(qc) - KOFF + HALF[a]);
            if (a < 2)
            begin
                f_next[a] = PW'(fc);
            end
        end
    end

    // Check the cell against the grid and form the base address
    always_comb
    begin
        bad_idx = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            if (i3_reg[a] < 0 || i3_reg[a] >= LIM[a])
            begin
                bad_idx = 1'b1;
            end
        end
        a0_next = 32'(i3_reg[0]) * 32'(GYZ) + 32'(i3_reg[1]) * 32'(GRID_Z)
                + 32'(i3_reg[2]);
    end

    // Corner address bound and corner weights
    always_comb
    begin
        a3        = a0_4_reg + 32'(GYZ + GRID_Z);
        bad_next5 = bad4_reg || (a3 > 32'(TABLE_DEPTH - 1));
        gx        = PW'(P) - f4_reg[0];
        gy        = PW'(P) - f4_reg[1];
        w_next[0] = WW'(gx) * WW'(gy);
        w_next[1] = WW'(f4_reg[0]) * WW'(gy);
        w_next[2] = WW'(gx) * WW'(f4_reg[1]);
        w_next[3] = WW'(f4_reg[0]) * WW'(f4_reg[1]);
    end

    // Hold payload through the front stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx1_reg    <= s_tdata[15:0];
            data1_reg   <= s_tdata[95:16];
            crd1_reg[0] <= CRD_W'($signed(s_tdata[111:96]));
            crd1_reg[1] <= CRD_W'($signed(s_tdata[127:112]));
            crd1_reg[2] <= s_tdata[145:128];
            idx2_reg    <= idx1_reg;
            data2_reg   <= data1_reg;
            for (int a = 0; a < 3; a++)
            begin
                xo2_reg[a]   <= xo_next[a];
                prod2_reg[a] <= (2*XW)'(xo_next[a]) * (2*XW)'(XMUL);
                i3_reg[a]    <= i_next[a];
            end
            idx3_reg  <= idx2_reg;
            data3_reg <= data2_reg;
            f3_reg    <= f_next;
            idx4_reg  <= idx3_reg;
            data4_reg <= data3_reg;
            f4_reg    <= f3_reg;
            bad4_reg  <= bad_idx;
            a0_4_reg  <= a0_next;
            idx5_reg  <= idx4_reg;
            data5_reg <= data4_reg;
            addr5_reg[0] <= a0_4_reg[AW-1:0];
            addr5_reg[1] <= AW'(a0_4_reg + 32'(GYZ));
            addr5_reg[2] <= AW'(a0_4_reg + 32'(GRID_Z));
            addr5_reg[3] <= a3[AW-1:0];
            w5_reg    <= w_next;
            w6_reg    <= w5_reg;
        end
    end

    assign ram_we = en && c5_reg.valid && (c5_reg.op == OP_WRITE);

    // One map copy per corner, all written together
    for (genvar k = 0; k < 4; k++)
    begin : g_ram
        fmbl_ram #(
            .WIDTH (ENTRY_W),
            .DEPTH (TABLE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we),
            .waddr (idx5_reg),
            .wdata (data5_reg),
            .re    (en),
            .raddr (addr5_reg[k]),
            .rdata (rdata[k])
        );
    end

    // One interpolation lane per field component
    for (genvar c = 0; c < 4; c++)
    begin : g_lane
        assign cv[c] = {rdata[3][VAL_W*c +: VAL_W], rdata[2][VAL_W*c +: VAL_W],
                        rdata[1][VAL_W*c +: VAL_W], rdata[0][VAL_W*c +: VAL_W]};

        fmbl_lane #(
            .WW       (WW),
            .PITCH_MM (PITCH_MM)
        ) u_lane (
            .clk        (clk),
            .en         (en),
            .corner_val (cv[c]),
            .weight     (w6_reg),
            .result     (res[c])
        );

        assign m_tdata[VAL_W*c +: VAL_W] = c11_reg.bad ? '0 : res[c];
    end

    assign m_tvalid   = c11_reg.valid && (c11_reg.op == OP_QUERY);
    assign m_tuser[0] = c11_reg.bad;

endmodule

// ----- design/fmbl_checker.sv -----
// Port-level checker for the field map bilinear lookup, bound to the top level.
module fmbl_checker import fmbl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [ENTRY_W-1:0] m_tdata,
    input logic [0:0]         m_tuser
);

`include "field_map_bilinear_lookup_assert.svh"

    // Input side opens exactly when the output side can move
    `FMBL_ASSERT_SAME(a_ready_tracks_out, 1'b1, s_tready == (!m_tvalid || m_tready), "ready does not follow output stall")

    // Cells off the grid give zero field
    `FMBL_ASSERT_SAME(a_oor_zero, m_tvalid && m_tuser[0], m_tdata == '0, "out of range beat carries data")

    // A stalled output beat stays put
    `FMBL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output beat changed")

endmodule

bind field_map_bilinear_lookup fmbl_checker u_fmbl_checker (.*);
